// ===== rtl/bam_led_matrix_row_scanner_assert.svh =====
// assertion macros used by the row scanner rtl
`ifndef BAM_LED_MATRIX_ROW_SCANNER_ASSERT_SVH
`define BAM_LED_MATRIX_ROW_SCANNER_ASSERT_SVH

// same-cycle implication
`define BAMLMS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bamlms assertion failed");

// next-cycle implication
`define BAMLMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bamlms assertion failed");

`endif

// ===== rtl/bamlms_pkg.sv =====
package bamlms_pkg;

	localparam int ROWS      = 4;
	localparam int COLUMNS   = 8;
	localparam int MAX_COLS  = 8;
	localparam int NUM_SLOTS = 6;
	localparam int PLANES    = 6;
	localparam int CHAN_BITS = 2;

	localparam int VAL_W     = 8;
	localparam int CH_W      = VAL_W - CHAN_BITS;
	localparam int PIX_W     = 3 * CH_W;
	localparam int LINE_W    = COLUMNS * PIX_W;
	localparam int ROW_W     = 2;
	localparam int COL_W     = 3;
	localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PLANE_W   = 3;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int TICK_W    = 6;
	localparam int DUR_W     = TICK_W + 1;
	localparam int CFG_IDX_W = $clog2(NUM_SLOTS);
	localparam int CFG_W     = PLANE_W;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [ROW_W-1:0] pixel_row;
		logic [COL_W-1:0] pixel_column;
		logic [VAL_W-1:0] red_value;
		logic [VAL_W-1:0] green_value;
		logic [VAL_W-1:0] blue_value;
	} item_t;

	typedef struct packed {
		logic [MAX_COLS-1:0] red_drive;
		logic [MAX_COLS-1:0] green_drive;
		logic [MAX_COLS-1:0] blue_drive;
		logic [ROW_W-1:0]    row_index;
	} result_t;

	// scan position handed from the sequencer to the datapath
	typedef struct packed {
		logic [ROW_AW-1:0]  row;
		logic [PLANE_W-1:0] plane;
	} scan_t;

endpackage

// ===== rtl/bamlms_ram.sv =====
module bamlms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bamlms_scan.sv =====
module bamlms_scan
	import bamlms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 advance,
	output scan_t                scan
);

	logic [PLANE_W-1:0] plane_q [NUM_SLOTS];
	logic [SLOT_W-1:0]  slot_q;
	logic [TICK_W-1:0]  tick_q;
	logic [ROW_AW-1:0]  row_q;

	logic [PLANE_W-1:0] plane;
	logic [TICK_W-1:0]  tick_inc;
	logic [DUR_W-1:0]   dur;
	logic               slot_end;

	assign plane = (int'(slot_q) < NUM_SLOTS) ? plane_q[slot_q] : plane_q[0];

	// slot length is 2^plane ticks, one tick for a plane with no stored bit
	always_comb begin
		tick_inc = tick_q + TICK_W'(1);
		if (int'(plane) < PLANES) begin
			dur = DUR_W'(1) << plane;
		end else begin
			dur = DUR_W'(1);
		end
		slot_end = (tick_inc == '0) || ({1'b0, tick_inc} >= dur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				plane_q[i] <= PLANE_W'(i);
			end
			slot_q <= '0;
			tick_q <= '0;
			row_q  <= '0;
		end else begin
			if (cfg_we) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (int'(cfg_addr) == i) begin
						plane_q[i] <= cfg_wdata;
					end
				end
			end
			if (advance) begin
				row_q <= (int'(row_q) >= ROWS - 1) ? '0 : row_q + ROW_AW'(1);
				if (slot_end) begin
					tick_q <= '0;
					slot_q <= (int'(slot_q) >= NUM_SLOTS - 1) ? '0 : slot_q + SLOT_W'(1);
				end else begin
					tick_q <= tick_inc;
				end
			end
		end
	end

	assign scan.row   = row_q;
	assign scan.plane = plane;

endmodule

// ===== rtl/bam_led_matrix_row_scanner.sv =====
// bam led matrix row scanner
// item channel: item_valid / item_stall carry one word of type item_t. a write
// word (kind = write) stores the top six bits of each colour at row and column;
// a tick word shows the active row for the current bit-angle slot and advances.
// result channel: result_valid / result_stall carry one result_t per tick word
// (inverted column masks, low lights a column, and the row shown). writes give
// no result.
// the frame store is a row-wide memory with a registered read. each word first
// reads its row, then merges and writes it back or forms the masks; item_stall
// stays high until the word is through, so the next word waits for it.
// a tick's result is valid once its masks are registered in the output register.
// a result sits in an output register; the next word is taken while it waits.
// a tick that finds that register still full and stalled waits in its merge step,
// holding item_stall high until the receiver takes the earlier result.
// reset: all pixels read as zero (per-row valid flags), row, slot and tick
// count clear, slot planes return to 0..5. there is no clearing pass.
// cfg_we writes slot plane cfg_addr (0..5); user must do so only while idle (unchecked).
module bam_led_matrix_row_scanner
	import bamlms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	`include "bam_led_matrix_row_scanner_assert.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_OP   = 1'b1;

	logic              state_q;
	item_t             item_s1;
	logic [ROW_AW-1:0] row_s1;
	logic              in_range_s1;
	logic [ROWS-1:0]   row_valid_q;
	logic              result_valid_q;
	result_t           result_q;

	scan_t             scan;
	logic              accept;
	logic              out_free;
	logic              advance;
	logic              done;
	logic              ram_re;
	logic              ram_we;
	logic [ROW_AW-1:0] ram_raddr;
	logic [LINE_W-1:0] ram_rdata;
	logic [LINE_W-1:0] line;
	logic [LINE_W-1:0] merged;
	logic [MAX_COLS-1:0] red_mask;
	logic [MAX_COLS-1:0] green_mask;
	logic [MAX_COLS-1:0] blue_mask;
	logic [PIX_W-1:0]  pixel;
	logic [PIX_W-1:0]  new_pixel;
	logic [CH_W-1:0]   red_ch;
	logic [CH_W-1:0]   green_ch;
	logic [CH_W-1:0]   blue_ch;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	assign ram_re    = accept;
	assign ram_raddr = (item.kind == KIND_TICK) ? scan.row : ROW_AW'(item.pixel_row);

	bamlms_ram #(
		.WIDTH(LINE_W),
		.DEPTH(ROWS)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_s1),
		.wdata (merged),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bamlms_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.scan      (scan)
	);

	// a row never written since reset reads as all zero
	assign line = row_valid_q[row_s1] ? ram_rdata : '0;

	always_comb begin
		new_pixel = {item_s1.red_value[VAL_W-1:CHAN_BITS],
			item_s1.green_value[VAL_W-1:CHAN_BITS],
			item_s1.blue_value[VAL_W-1:CHAN_BITS]};
		merged     = line;
		red_mask   = '0;
		green_mask = '0;
		blue_mask  = '0;
		pixel      = '0;
		red_ch     = '0;
		green_ch   = '0;
		blue_ch    = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			if (int'(item_s1.pixel_column) == c) begin
				merged[c*PIX_W +: PIX_W] = new_pixel;
			end
			pixel    = line[c*PIX_W +: PIX_W];
			red_ch   = pixel[3*CH_W-1:2*CH_W];
			green_ch = pixel[2*CH_W-1:CH_W];
			blue_ch  = pixel[CH_W-1:0];
			// planes past the stored bits leave every column off
			if (int'(scan.plane) < PLANES) begin
				red_mask[c]   = red_ch[scan.plane];
				green_mask[c] = green_ch[scan.plane];
				blue_mask[c]  = blue_ch[scan.plane];
			end
		end
	end

	assign ram_we  = (state_q == ST_OP) && (item_s1.kind == KIND_WRITE) && in_range_s1;
	assign advance = (state_q == ST_OP) && (item_s1.kind == KIND_TICK) && out_free;
	assign done    = (state_q == ST_OP) && ((item_s1.kind == KIND_WRITE) || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_valid_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ram_we) begin
				row_valid_q[row_s1] <= 1'b1;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			row_s1      <= ram_raddr;
			in_range_s1 <= (int'(item.pixel_row) < ROWS) && (int'(item.pixel_column) < COLUMNS);
		end
		if (advance) begin
			result_q.red_drive   <= ~red_mask;
			result_q.green_drive <= ~green_mask;
			result_q.blue_drive  <= ~blue_mask;
			result_q.row_index   <= ROW_W'(row_s1);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`BAMLMS_ASSERT_NEXT(a_accept_to_op, accept, state_q == ST_OP)
	`BAMLMS_ASSERT_NOW(a_no_read_during_write, ram_we, !ram_re)
	`BAMLMS_ASSERT_NOW(a_result_from_tick, $rose(result_valid),
		$past(state_q == ST_OP && item_s1.kind == KIND_TICK))
	`BAMLMS_ASSERT_NEXT(a_write_marks_row, ram_we, row_valid_q[$past(row_s1)])

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench
	import bamlms_pkg::*;
();

	localparam int LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// scanner state as the bench sees it
	logic [PIX_W-1:0]   pixel_mem [ROWS*MAX_COLS];
	logic [PLANE_W-1:0] plane_reg [NUM_SLOTS];
	int unsigned        scan_row;
	int unsigned        scan_slot;
	int unsigned        scan_ticks;

	item_t   words_pending[$];
	result_t drives_due[$];
	int      errors = 0;
	int      cycles = 0;
	int      hold_left = 0;
	bit      calm = 1'b0;

	bam_led_matrix_row_scanner DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #1 clk = ~clk;

	initial begin
		for (int i = 0; i < ROWS*MAX_COLS; i++)
			pixel_mem[i] = '0;
		for (int i = 0; i < NUM_SLOTS; i++)
			plane_reg[i] = PLANE_W'(i);
		scan_row = 0;
		scan_slot = 0;
		scan_ticks = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// stores a pixel, or works out the row drive a tick word shows and steps the scan
	function automatic void scan_word(item_t w);
		int unsigned      plane;
		int unsigned      span;
		logic [PIX_W-1:0] px;
		result_t          r;
		if (w.kind == KIND_WRITE) begin
			if (w.pixel_row < ROWS && w.pixel_column < COLUMNS)
				pixel_mem[w.pixel_row*MAX_COLS + w.pixel_column] =
					{w.red_value[VAL_W-1:CHAN_BITS], w.green_value[VAL_W-1:CHAN_BITS],
					 w.blue_value[VAL_W-1:CHAN_BITS]};
			return;
		end
		plane = plane_reg[scan_slot];
		r.red_drive = '1;
		r.green_drive = '1;
		r.blue_drive = '1;
		r.row_index = ROW_W'(scan_row);
		if (plane < PLANES) begin
			for (int c = 0; c < COLUMNS; c++) begin
				px = pixel_mem[scan_row*MAX_COLS + c];
				if (px[2*CH_W + plane]) r.red_drive[c] = 1'b0;
				if (px[CH_W + plane]) r.green_drive[c] = 1'b0;
				if (px[plane]) r.blue_drive[c] = 1'b0;
			end
		end
		drives_due.push_back(r);
		scan_row = (scan_row + 1 >= ROWS) ? 0 : scan_row + 1;
		// planes 6 and 7 hold for a single tick
		span = (plane < PLANES) ? (1 << plane) : 1;
		scan_ticks = (scan_ticks + 1) & 6'h3f;
		if (scan_ticks == 0 || scan_ticks >= span) begin
			scan_ticks = 0;
			scan_slot = (scan_slot + 1 >= NUM_SLOTS) ? 0 : scan_slot + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				scan_word(item);
			if (!item_valid || !item_stall) begin
				if (words_pending.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
					item <= words_pending.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (drives_due.size() == 0) begin
					$error("row drive word with none expected: %h", result);
					errors++;
				end else begin
					want = drives_due.pop_front();
					if (result.red_drive !== want.red_drive) begin
						$error("red_drive expected %h actual %h", want.red_drive, result.red_drive);
						errors++;
					end
					if (result.green_drive !== want.green_drive) begin
						$error("green_drive expected %h actual %h", want.green_drive,
							result.green_drive);
						errors++;
					end
					if (result.blue_drive !== want.blue_drive) begin
						$error("blue_drive expected %h actual %h", want.blue_drive,
							result.blue_drive);
						errors++;
					end
					if (result.row_index !== want.row_index) begin
						$error("row_index expected %0d actual %0d", want.row_index,
							result.row_index);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !calm && $urandom_range(99) < 29;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_pixel(input int r, input int c, input int rv, input int gv, input int bv);
		item_t w;
		w = '0;
		w.kind = KIND_WRITE;
		w.pixel_row = ROW_W'(r);
		w.pixel_column = COL_W'(c);
		w.red_value = VAL_W'(rv);
		w.green_value = VAL_W'(gv);
		w.blue_value = VAL_W'(bv);
		words_pending.push_back(w);
	endtask

	task automatic push_ticks(input int n);
		item_t w;
		w = '0;
		w.kind = KIND_TICK;
		repeat (n) words_pending.push_back(w);
	endtask

	// random words, tick_pct of them ticks; tick words carry junk in the pixel fields
	task automatic feed(input int n, input int tick_pct);
		item_t w;
		repeat (n) begin
			w = item_t'($bits(item_t)'($urandom));
			w.kind = ($urandom_range(99) < tick_pct) ? KIND_TICK : KIND_WRITE;
			words_pending.push_back(w);
		end
	endtask

	task automatic wait_idle();
		while (words_pending.size() != 0 || item_valid || drives_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// p[i] goes to slot i
	task automatic load_planes(input logic [NUM_SLOTS-1:0][CFG_W-1:0] p);
		for (int i = 0; i < NUM_SLOTS; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= CFG_IDX_W'(i);
			cfg_wdata <= p[i];
			plane_reg[i] = p[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [NUM_SLOTS-1:0][CFG_W-1:0] planes;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// blank frame first, then corner pixels and the dropped low bits
		push_ticks(1);
		push_pixel(0, 0, 255, 255, 255);
		push_pixel(0, 7, 8'hfc, 8'h00, 8'h03);
		push_pixel(3, 7, 8'h80, 8'h40, 8'hff);
		push_pixel(3, 0, 8'h00, 8'hff, 8'h00);
		push_pixel(1, 3, 8'h55, 8'haa, 8'h0f);
		push_pixel(2, 5, 8'h24, 8'h90, 8'hc8);
		push_ticks(8);
		push_pixel(0, 0, 0, 0, 0);
		push_ticks(8);
		wait_idle();

		load_planes({3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5});
		feed(200, 55);
		wait_idle();

		load_planes('0);
		calm = 1'b1;
		feed(150, 55);
		wait_idle();
		calm = 1'b0;

		// receiver blocks for a long stretch while the sender keeps offering
		load_planes({6{3'd5}});
		feed(150, 60);
		hold_left = 400;
		wait_idle();

		load_planes({3'd3, 3'd6, 3'd7, 3'd0, 3'd7, 3'd6});
		feed(150, 55);
		wait_idle();

		for (int i = 0; i < NUM_SLOTS; i++)
			planes[i] = CFG_W'($urandom_range(7));
		load_planes(planes);
		feed(200, 55);
		wait_idle();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
